/* design/bda_pkg.sv */
// Shared types and constants for the binary to decimal ASCII converter.
package bda_pkg;

  localparam int unsigned VALUE_W            = 32;
  localparam int unsigned DIGIT_W            = 6;
  localparam int unsigned DEFAULT_VALUE_BITS = 32;
  localparam logic [DIGIT_W-1:0] ASCII_ZERO  = 6'd48;

  // Decimal digits needed for a value of the given width: floor(bits*log10(2))+1.
  function automatic int unsigned num_digits(input int unsigned bits);
    num_digits = ((bits * 1233) >> 12) + 1;
  endfunction

  typedef struct packed {
    logic load;   // capture a new value, clear the BCD register
    logic shift;  // one add-3 and shift step
    logic seek;   // point at the leading nonzero digit
    logic emit;   // load the next digit into the output register
  } bda_cmd_t;

  typedef struct packed {
    logic shift_done;  // the step now running is the final one
    logic last_digit;  // the digit pointer is at the units digit
  } bda_sts_t;

endpackage

/* design/bda_if.sv */
// Valid/ready stream interfaces for the input values and output characters.
interface bda_in_if
  import bda_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bda_out_if
  import bda_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit_char;
  logic               last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

/* design/bda_dpath.sv */
// Datapath: iterative double-dabble conversion, digit pointer and output payload register.
module bda_dpath
  import bda_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bda_cmd_t           cmd_i,
  output bda_sts_t           sts_o,
  input  logic [VALUE_W-1:0] value_i,
  output logic [DIGIT_W-1:0] digit_char_o,
  output logic               last_o
);

  localparam int unsigned NDIG  = num_digits(VALUE_BITS);
  localparam int unsigned BCD_W = 4 * NDIG;
  localparam int unsigned CNT_W = $clog2(VALUE_BITS);
  localparam int unsigned IDX_W = $clog2(NDIG);

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d, bcd_adj;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      idx_q, idx_d, lead_idx;
  logic [3:0]            sel_digit;
  logic [DIGIT_W-1:0]    digit_q, digit_d;
  logic                  last_q, last_d;

  // add 3 to every BCD digit of 5 or more
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // highest nonzero digit; units digit when the value is zero
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        lead_idx = IDX_W'(i);
      end
    end
  end

  assign sel_digit = bcd_q[4*idx_q +: 4];

  always_comb begin
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    digit_d = digit_q;
    last_d  = last_q;
    if (cmd_i.load) begin
      bin_d = VALUE_BITS'(value_i);
      bcd_d = '0;
      cnt_d = CNT_W'(VALUE_BITS - 1);
    end
    if (cmd_i.shift) begin
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end
    if (cmd_i.seek) begin
      idx_d = lead_idx;
    end
    if (cmd_i.emit) begin
      digit_d = ASCII_ZERO + DIGIT_W'(sel_digit);
      last_d  = (idx_q == '0);
      idx_d   = idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
    digit_q <= digit_d;
    last_q  <= last_d;
  end

  assign sts_o.shift_done = (cnt_q == '0);
  assign sts_o.last_digit = (idx_q == '0);
  assign digit_char_o     = digit_q;
  assign last_o           = last_q;

endmodule

/* design/bda_ctrl.sv */
// Controller: sequences load, conversion, digit seek and emission per value.
module bda_ctrl
  import bda_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bda_cmd_t cmd_o,
  input  bda_sts_t sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SEEK,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) begin
          state_d = ST_SEEK;
        end
      end
      ST_SEEK: begin
        cmd_o.seek = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.last_digit) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* design/binary_to_decimal_ascii.sv */
// Top level of the binary to decimal ASCII converter.
//
// Input channel in_i carries one unsigned value per transaction; output
// channel out_o carries one ASCII digit ('0'..'9') per transaction, most
// significant first, without leading zeros, with last set on the units digit.
// Zero gives the single character '0'.
// Per value: double-dabble shifting of all VALUE_BITS bits (one bit per
// cycle through the shared add-3 stage), then a step to locate the leading
// digit, then the digits one at a time into the output register, held while
// the output stalls. The next value is taken only after the units digit has
// been loaded into the output register.
// in_i.ready is high only between values; a finished digit may still sit in
// the output register while the next value is taken.
// A stalled receiver holds the current digit; conversion of the digit string
// is paused until it is taken. Reset empties the output register and returns
// the controller to idle; no other state is kept between values.
module binary_to_decimal_ascii
  import bda_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input logic            clk_i,
  input logic            rst_ni,
  bda_in_if.sink         in_i,
  bda_out_if.source      out_o
);

  bda_cmd_t cmd;
  bda_sts_t sts;

  bda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bda_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (in_i.value),
    .digit_char_o (out_o.digit_char),
    .last_o       (out_o.last)
  );

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.shift, cmd.seek, cmd.emit}))
    else $error("more than one datapath command at once");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> cmd.load)
    else $error("input transaction without load");

  a_load_then_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> (cmd.shift && !in_i.ready))
    else $error("conversion did not start after load");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && sts.last_digit) |=> (in_i.ready && out_o.valid && out_o.last))
    else $error("run did not end on the units digit");

endmodule
